// File: rtl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg: shared definitions for the 9x9 RGB box blur
// Window geometry, counter widths, divider constants and the types that
// travel between the line banks, the column-sum cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bbr_pkg;

  localparam int WINDOW     = 9;
  localparam int HALF       = WINDOW / 2;
  localparam int BANKS      = WINDOW - 1;
  localparam int BANK_W     = 3;
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 13;
  localparam int ROWX_W     = ROW_W + 1;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = NUM_CH * CH_W;
  localparam int VSUM_W     = 12;   // 9 * 255
  localparam int HSUM_W     = 14;   // 5 * 2295
  localparam int TOT_W      = 15;   // 81 * 255
  localparam int TICK_W     = 14;
  localparam int WCFG_W     = 12;
  localparam int HCFG_W     = 13;
  localparam int CFG_DATA_W = 13;

  // floor(x / 81) = (x * 25891) >> 21 for every x below 2^15
  localparam logic [TOT_W-1:0] DIV_MUL   = 15'd25891;
  localparam int               DIV_SHIFT = 21;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WCFG_W-1:0] WIDTH_MAX    = 12'd2048;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // per-channel sums, index 2 red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][VSUM_W-1:0] vsum_t;

  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] tag;
    vsum_t            v;
  } cell_t;

endpackage

`default_nettype wire

// File: rtl/bbr_line_bank.sv
// ----------------------------------------------------------------------------
// bbr_line_bank: one row of the line store
// Single write port, single registered read port, read-first on collision.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_line_bank
  import bbr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [COL_W-1:0] waddr,
  input  wire logic [PIX_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [COL_W-1:0] raddr,
  output logic      [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // old contents come out when the same address is written in this cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bbr_cell.sv
// ----------------------------------------------------------------------------
// bbr_cell: one column-sum cell of the horizontal window
// Holds one column sum with its row tag, hands it on each shift, and gives
// its sum when the tag matches the row of the pixel being averaged.
// ----------------------------------------------------------------------------
`default_nettype none

module bbr_cell
  import bbr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire cell_t            din,
  input  wire logic [ROW_W-1:0] query_row,
  output cell_t                 dout,
  output vsum_t                 contrib
);

  logic             valid;
  logic [ROW_W-1:0] tag;
  vsum_t            v;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tag <= din.tag;
      v   <= din.v;
    end
  end

  assign dout    = '{valid: valid, tag: tag, v: v};
  assign contrib = (valid && (tag == query_row)) ? v : '0;

endmodule

`default_nettype wire

// File: rtl/box_blur_9x9_rgb_top.sv
// ----------------------------------------------------------------------------
// box_blur_9x9_rgb_top: streaming 9x9 box blur over packed RGB pixels
// Line store, vertical column sums, a chain of nine column cells and a
// reciprocal divider give floor(sum / 81) per channel with zero padding.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the s_axis side, one item per clock when
// both sides keep up; tuser = 1 marks a drain item. Results leave on m_axis
// in raster order, tlast on the last pixel of the frame. Output pixel p is
// released by the input item numbered p + 4*width + min(4, width-1) within
// the frame, so after the last pixel 4*width + min(4, width-1) drain items
// (or further pixels, which then only count as drain) flush the frame tail.
// From an accepted item to its result the pipeline runs through the
// line-bank read, the column adder, the cell chain, two adder stages and
// the divider multiply. The line store is eight 2048-pixel banks,
// one per buffered row; the ninth row of each column is the arriving pixel.
// Writing image_width or image_height restarts the frame; write them only
// while the block is idle. A width of 0 acts as 1 and above 2048 as 2048,
// a height of 0 acts as 1.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_9x9_rgb_top
  import bbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [PIX_W-1:0]      s_axis_tdata,   // pixel_rgb[23:0]
  input  wire logic                  s_axis_tuser,   // operation[0]
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [PIX_W-1:0]           m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                       m_axis_tlast    // frame_last
);

  // ---------------------------------------------------------------- config
  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data[WCFG_W-1:0];
      end else begin
        image_height <= cfg_data;
      end
    end
  end

  logic [WCFG_W-1:0] w_eff;
  logic [HCFG_W-1:0] h_eff;
  logic [COL_W-1:0]  w_m1;
  logic [TICK_W-1:0] w4;
  logic [TICK_W-1:0] lag;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WCFG_W'(1);
    end else if (image_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? HCFG_W'(1) : image_height;
    w_m1  = COL_W'(w_eff - WCFG_W'(1));
    w4    = {w_eff, 2'b00};
    // column sums run ahead of the outputs by min(4, width-1)
    lag   = w4 + ((w_m1 < COL_W'(HALF)) ? TICK_W'(w_m1) : TICK_W'(HALF));
  end

  // -------------------------------------------------------------- handshake
  // every stage advances together; the output register parts the two sides
  logic adv;
  logic acc;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;

  // --------------------------------------------------------- frame counters
  logic [COL_W-1:0]  input_col;
  logic [ROW_W-1:0]  input_row;
  logic [TICK_W-1:0] tcnt;      // items of the frame, held once past lag
  logic [COL_W-1:0]  jcol;      // position of the next column sum
  logic [ROW_W-1:0]  jrow;
  logic [COL_W-1:0]  pcol;      // position of the next output pixel
  logic [ROW_W-1:0]  prow;

  logic inputs_done, is_data, wr, counted, j_on, p_on, out_en, last, frame_end;

  always_comb begin
    inputs_done = input_row >= h_eff;
    is_data     = (s_axis_tuser == OP_PIXEL);
    wr          = acc && is_data && !inputs_done;
    // a drain item before the frame is fully in does nothing
    counted     = acc && (is_data || inputs_done);
    j_on        = tcnt >= w4;
    p_on        = tcnt >= lag;
    out_en      = counted && p_on && (prow < h_eff);
    last        = (prow == h_eff - HCFG_W'(1)) && (pcol == w_m1);
    frame_end   = out_en && last;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we || frame_end) begin
      input_col <= '0;
      input_row <= '0;
      tcnt      <= '0;
      jcol      <= '0;
      jrow      <= '0;
      pcol      <= '0;
      prow      <= '0;
    end else if (counted) begin
      if (wr) begin
        if (input_col == w_m1) begin
          input_col <= '0;
          input_row <= input_row + ROW_W'(1);
        end else begin
          input_col <= input_col + COL_W'(1);
        end
      end
      if (tcnt < lag) begin
        tcnt <= tcnt + TICK_W'(1);
      end
      if (j_on) begin
        if (jcol == w_m1) begin
          jcol <= '0;
          jrow <= jrow + ROW_W'(1);
        end else begin
          jcol <= jcol + COL_W'(1);
        end
      end
      if (out_en) begin
        if (pcol == w_m1) begin
          pcol <= '0;
          prow <= prow + ROW_W'(1);
        end else begin
          pcol <= pcol + COL_W'(1);
        end
      end
    end
  end

  // ------------------------------------------------------------ line store
  // bank b holds rows equal to b mod 8; the bank being written at jcol is
  // read first, which yields the row eight above the arriving pixel
  logic [BANKS-1:0][PIX_W-1:0] bank_q;

  genvar b;
  generate
    for (b = 0; b < BANKS; b++) begin : g_bank
      bbr_line_bank u_bank (
        .clk   (clk),
        .we    (wr && (input_row[BANK_W-1:0] == BANK_W'(b))),
        .waddr (input_col),
        .wdata (s_axis_tdata),
        .re    (adv),
        .raddr (jcol),
        .rdata (bank_q[b])
      );
    end
  endgenerate

  // row mask of the nine taps: rows jrow-4 .. jrow+4 inside the frame
  logic [WINDOW-1:0] mask_next;

  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      mask_next[k] = (({1'b0, jrow} + ROWX_W'(k)) >= ROWX_W'(HALF)) &&
                     (({1'b0, jrow} + ROWX_W'(k)) < ({1'b0, h_eff} + ROWX_W'(HALF)));
    end
  end

  // --------------------------------------------------------------- stage 1
  logic              s1_out_en, s1_last, s1_push, s1_restart, s1_jvalid;
  logic [ROW_W-1:0]  s1_prow, s1_tag;
  logic [WINDOW-1:0] s1_mask;
  logic [BANK_W-1:0] s1_base;
  logic [PIX_W-1:0]  s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_out_en  <= 1'b0;
      s1_push    <= 1'b0;
    end else if (adv) begin
      s1_out_en  <= out_en;
      s1_push    <= counted;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last    <= last;
      s1_prow    <= prow;
      s1_restart <= (tcnt == '0);
      s1_jvalid  <= j_on;
      s1_tag     <= jrow;
      s1_mask    <= mask_next;
      s1_base    <= jrow[BANK_W-1:0];
      s1_pix     <= s_axis_tdata;
    end
  end

  // vertical sum of one column over nine rows
  logic [WINDOW-1:0][PIX_W-1:0] tap;
  vsum_t                        vsum_next;

  always_comb begin
    for (int k = 0; k < BANKS; k++) begin
      tap[k] = bank_q[BANK_W'(s1_base + BANK_W'(k + HALF))];
    end
    tap[WINDOW-1] = s1_pix;
    vsum_next = '0;
    for (int k = 0; k < WINDOW; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (s1_mask[k]) begin
          vsum_next[c] = vsum_next[c] + VSUM_W'(tap[k][c*CH_W +: CH_W]);
        end
      end
    end
  end

  // --------------------------------------------------------------- stage 2
  logic             s2_out_en, s2_last, s2_push, s2_restart, s2_jvalid;
  logic [ROW_W-1:0] s2_prow, s2_tag;
  vsum_t            s2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_out_en <= 1'b0;
      s2_push   <= 1'b0;
    end else if (adv) begin
      s2_out_en <= s1_out_en;
      s2_push   <= s1_push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last    <= s1_last;
      s2_prow    <= s1_prow;
      s2_restart <= s1_restart;
      s2_jvalid  <= s1_jvalid;
      s2_tag     <= s1_tag;
      s2_v       <= vsum_next;
    end
  end

  // ------------------------------------------------------------ cell chain
  // shift in one column sum per counted item; the first item of a frame
  // drops whatever the chain still holds from before
  logic             s3_out_en, s3_last;
  logic [ROW_W-1:0] s3_prow;
  cell_t            cell_in  [WINDOW];
  cell_t            cell_out [WINDOW];
  vsum_t            contrib  [WINDOW];
  logic             shift;

  assign shift = adv && s2_push;

  always_comb begin
    cell_in[0] = '{valid: s2_jvalid, tag: s2_tag, v: s2_v};
    for (int k = 1; k < WINDOW; k++) begin
      cell_in[k] = s2_restart ? '0 : cell_out[k-1];
    end
  end

  genvar k;
  generate
    for (k = 0; k < WINDOW; k++) begin : g_cell
      bbr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .din       (cell_in[k]),
        .query_row (s3_prow),
        .dout      (cell_out[k]),
        .contrib   (contrib[k])
      );
    end
  endgenerate

  // --------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_out_en <= 1'b0;
    end else if (adv) begin
      s3_out_en <= s2_out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      s3_prow <= s2_prow;
    end
  end

  // horizontal sum in two halves over the cells of the output row
  logic [NUM_CH-1:0][HSUM_W-1:0] lo_next, hi_next;

  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int i = 0; i <= HALF; i++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        lo_next[c] = lo_next[c] + HSUM_W'(contrib[i][c]);
      end
    end
    for (int i = HALF + 1; i < WINDOW; i++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        hi_next[c] = hi_next[c] + HSUM_W'(contrib[i][c]);
      end
    end
  end

  // --------------------------------------------------------------- stage 4
  logic                          s4_out_en, s4_last;
  logic [NUM_CH-1:0][HSUM_W-1:0] s4_lo, s4_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_out_en <= 1'b0;
    end else if (adv) begin
      s4_out_en <= s3_out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_last <= s3_last;
      s4_lo   <= lo_next;
      s4_hi   <= hi_next;
    end
  end

  // --------------------------------------------------------------- stage 5
  logic                         s5_out_en, s5_last;
  logic [NUM_CH-1:0][TOT_W-1:0] s5_tot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_out_en <= 1'b0;
    end else if (adv) begin
      s5_out_en <= s4_out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_last <= s4_last;
      for (int c = 0; c < NUM_CH; c++) begin
        s5_tot[c] <= TOT_W'(s4_lo[c]) + TOT_W'(s4_hi[c]);
      end
    end
  end

  // divide by 81 through the reciprocal multiply
  logic [NUM_CH-1:0][2*TOT_W-1:0] prod;
  logic [NUM_CH-1:0][CH_W-1:0]    avg;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = (2*TOT_W)'(s5_tot[c]) * (2*TOT_W)'(DIV_MUL);
      avg[c]  = prod[c][DIV_SHIFT +: CH_W];
    end
  end

  // --------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s5_out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {avg[0], avg[1], avg[2]};
      m_axis_tlast <= s5_last;
    end
  end

endmodule

`default_nettype wire
